/* rtl/core/rc_pkg.sv */
// Radix converter package: sequencer states, divider request/response
// structs, base clamp and reciprocal table. No dependencies.

package rc_pkg;

  localparam int NumW          = 30;
  localparam int DigW          = 4;
  localparam int MaxOutDigits  = 30;
  localparam int OutIdxW       = $clog2(MaxOutDigits);
  localparam int RecipW        = 32;
  localparam logic [DigW-1:0] DecRadix = 4'd10;
  localparam logic [DigW-1:0] MinBase  = 4'd2;
  localparam logic [DigW-1:0] InBaseRst  = 4'd10;
  localparam logic [DigW-1:0] OutBaseRst = 4'd2;

  localparam logic [0:0] RegInBase  = 1'b0;
  localparam logic [0:0] RegOutBase = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DDIV,
    S_DWAIT,
    S_CHK,
    S_ERR,
    S_ODIV,
    S_OWAIT,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic            start;
    logic [NumW-1:0] dividend;
    logic [DigW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [NumW-1:0] quot;
    logic [DigW-1:0] rem;
  } div_rsp_t;

  function automatic logic [DigW-1:0] clamp_base(input logic [DigW-1:0] b);
    logic [DigW-1:0] r;
    if (b < MinBase) r = MinBase;
    else if (b > DecRadix) r = DecRadix;
    else r = b;
    return r;
  endfunction

  // floor(2^32 / d)
  function automatic logic [RecipW-1:0] recip(input logic [DigW-1:0] d);
    logic [RecipW-1:0] m;
    case (d)
      4'd2:    m = 32'd2147483648;
      4'd3:    m = 32'd1431655765;
      4'd4:    m = 32'd1073741824;
      4'd5:    m = 32'd858993459;
      4'd6:    m = 32'd715827882;
      4'd7:    m = 32'd613566756;
      4'd8:    m = 32'd536870912;
      4'd9:    m = 32'd477218588;
      default: m = 32'd429496729;
    endcase
    return m;
  endfunction

endpackage

/* rtl/core/rc_div.sv */
// Shared divide-by-small-base unit: reciprocal multiply, then one correction.
// The product and the corrected result are registered in turn. Uses rc_pkg.

module rc_div (
  input  logic              clk,
  input  logic              rst,
  input  rc_pkg::div_req_t  req,
  output rc_pkg::div_rsp_t  rsp
);

  localparam int ProdW = rc_pkg::NumW + rc_pkg::RecipW;

  logic                          a_vld;
  logic [rc_pkg::NumW-1:0]       a_val;
  logic [rc_pkg::DigW-1:0]       a_d;
  logic [ProdW-1:0]              a_prod;

  logic [rc_pkg::NumW-1:0]       q_est;
  logic [rc_pkg::NumW+rc_pkg::DigW-1:0] qd;
  logic [rc_pkg::NumW-1:0]       r_raw;
  logic                          corr;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld    <= 1'b0;
      rsp.done <= 1'b0;
    end else begin
      a_vld    <= req.start;
      rsp.done <= a_vld;
    end
    a_val  <= req.dividend;
    a_d    <= req.divisor;
    a_prod <= {{rc_pkg::RecipW{1'b0}}, req.dividend} *
              {{rc_pkg::NumW{1'b0}}, rc_pkg::recip(req.divisor)};
    rsp.quot <= corr ? q_est + 1'b1 : q_est;
    rsp.rem  <= corr ? rc_pkg::DigW'(r_raw - {{(rc_pkg::NumW-rc_pkg::DigW){1'b0}}, a_d})
                     : r_raw[rc_pkg::DigW-1:0];
  end

  always_comb begin
    q_est = a_prod[ProdW-1:rc_pkg::RecipW];
    qd    = {{rc_pkg::DigW{1'b0}}, q_est} * {{rc_pkg::NumW{1'b0}}, a_d};
    r_raw = a_val - qd[rc_pkg::NumW-1:0];
    corr  = r_raw >= {{(rc_pkg::NumW-rc_pkg::DigW){1'b0}}, a_d};
  end

endmodule

/* rtl/core/radix_converter_top.sv */
// Radix converter top level: config registers, sequencer, digit store.
// Depends on rc_pkg and rc_div.
//
// Usage:
//   Input channel (in_valid/in_stall, numeral): one word per numeral. The
//   lowest NUMERAL_DIGITS decimal digits are read as digits in base in_base.
//   Output channel (out_valid/out_stall, digit/last/bad_digit): the value's
//   digits in base out_base, most significant first, last set on the final
//   word. A digit not below in_base gives one word with bad_digit and last set.
//   Bases are written through cfg_we/cfg_index/cfg_data while idle; values
//   outside 2..10 saturate.
// Timing:
//   in_stall is high from acceptance until the final output word is taken.
//   Digit extraction: one divider request per decimal digit, the value updated
//   from each response, then a check state; conversion: one divider request
//   per output digit k, then k emit words. All divides go through the
//   shared divider, one at a time.
// Reset: in_base = 10, out_base = 2, sequencer idle, no output word.
// A stalled output holds its word; the block waits with it.

module radix_converter_top #(
  parameter int NUMERAL_DIGITS = 9
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [0:0]               cfg_index,
  input  logic [rc_pkg::DigW-1:0]  cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [rc_pkg::NumW-1:0]  numeral,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [rc_pkg::DigW-1:0]  digit,
  output logic                     last,
  output logic                     bad_digit
);

  localparam int CntW = (NUMERAL_DIGITS > 1) ? $clog2(NUMERAL_DIGITS) : 1;

  logic [rc_pkg::DigW-1:0]    in_base;
  logic [rc_pkg::DigW-1:0]    out_base;
  logic [rc_pkg::DigW-1:0]    ib;
  logic [rc_pkg::DigW-1:0]    ob;

  rc_pkg::state_t             state;
  rc_pkg::state_t             state_next;
  rc_pkg::div_req_t           div_req;
  rc_pkg::div_rsp_t           div_rsp;

  logic [rc_pkg::NumW-1:0]    n;
  logic [rc_pkg::NumW-1:0]    value;
  logic [rc_pkg::NumW-1:0]    pw;
  logic                       bad;
  logic [CntW-1:0]            cnt;
  logic [rc_pkg::OutIdxW-1:0] ocnt;
  logic [rc_pkg::OutIdxW-1:0] eidx;
  logic [rc_pkg::DigW-1:0]    rev [rc_pkg::MaxOutDigits];

  logic                       in_acc;
  logic                       out_acc;
  logic                       dec_last;
  logic                       out_done;

  assign ib      = rc_pkg::clamp_base(in_base);
  assign ob      = rc_pkg::clamp_base(out_base);
  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign dec_last = cnt == CntW'(NUMERAL_DIGITS - 1);
  assign out_done = (div_rsp.quot == '0) || (ocnt == rc_pkg::OutIdxW'(rc_pkg::MaxOutDigits - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      in_base  <= rc_pkg::InBaseRst;
      out_base <= rc_pkg::OutBaseRst;
    end else if (cfg_we) begin
      case (cfg_index)
        rc_pkg::RegInBase:  in_base  <= cfg_data;
        rc_pkg::RegOutBase: out_base <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next       = state;
    div_req.start    = 1'b0;
    div_req.dividend = n;
    div_req.divisor  = rc_pkg::DecRadix;
    in_stall         = 1'b1;
    out_valid        = 1'b0;
    case (state)
      rc_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) state_next = rc_pkg::S_DDIV;
      end
      rc_pkg::S_DDIV: begin
        div_req.start = 1'b1;
        state_next    = rc_pkg::S_DWAIT;
      end
      rc_pkg::S_DWAIT: begin
        if (div_rsp.done) state_next = dec_last ? rc_pkg::S_CHK : rc_pkg::S_DDIV;
      end
      rc_pkg::S_CHK: begin
        state_next = bad ? rc_pkg::S_ERR : rc_pkg::S_ODIV;
      end
      rc_pkg::S_ERR: begin
        out_valid = 1'b1;
        if (!out_stall) state_next = rc_pkg::S_IDLE;
      end
      rc_pkg::S_ODIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = value;
        div_req.divisor  = ob;
        state_next       = rc_pkg::S_OWAIT;
      end
      rc_pkg::S_OWAIT: begin
        if (div_rsp.done) state_next = out_done ? rc_pkg::S_EMIT : rc_pkg::S_ODIV;
      end
      rc_pkg::S_EMIT: begin
        out_valid = 1'b1;
        if (!out_stall && eidx == '0) state_next = rc_pkg::S_IDLE;
      end
      default: state_next = rc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      n     <= numeral;
      value <= '0;
      pw    <= rc_pkg::NumW'(1);
      bad   <= 1'b0;
      cnt   <= '0;
      ocnt  <= '0;
    end
    if (state == rc_pkg::S_DWAIT && div_rsp.done) begin
      n     <= div_rsp.quot;
      value <= rc_pkg::NumW'(value +
               {{(rc_pkg::NumW-rc_pkg::DigW){1'b0}}, div_rsp.rem} * pw);
      pw    <= rc_pkg::NumW'(pw * {{(rc_pkg::NumW-rc_pkg::DigW){1'b0}}, ib});
      bad   <= bad || (div_rsp.rem >= ib);
      cnt   <= cnt + 1'b1;
    end
    if (state == rc_pkg::S_OWAIT && div_rsp.done) begin
      rev[ocnt] <= div_rsp.rem;
      value     <= div_rsp.quot;
      ocnt      <= ocnt + 1'b1;
      eidx      <= ocnt;
    end
    if (state == rc_pkg::S_EMIT && out_acc && eidx != '0) begin
      eidx <= eidx - 1'b1;
    end
  end

  rc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign bad_digit = state == rc_pkg::S_ERR;
  assign digit     = bad_digit ? '0 : rev[eidx];
  assign last      = bad_digit || eidx == '0;

  a_no_out_after_in: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !out_valid)
    else $error("output word right after input acceptance");

  a_bad_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_digit |-> last && digit == '0)
    else $error("bad-digit word not a single zero word");

  a_div_rsp_expected: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == rc_pkg::S_DWAIT || state == rc_pkg::S_OWAIT))
    else $error("divider response outside a wait state");

  a_busy_when_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input open while output pending");

endmodule
